/* design/esrs_pkg.sv */
package esrs_pkg;

	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	localparam logic [13:0] DATA_MASK     = 14'h3FFF;
	localparam logic [13:0] ADDR_NOP      = 14'h0000;
	localparam logic [13:0] ADDR_ERRFL    = 14'h0001;
	localparam logic [13:0] ADDR_DIAAGC   = 14'h3FFC;
	localparam logic [13:0] ADDR_ZPOSL    = 14'h0017;
	localparam logic [13:0] ADDR_ANG_UNC  = 14'h3FFE;
	localparam logic [13:0] ADDR_ANG_COMP = 14'h3FFF;
	localparam logic [13:0] ZPOS_HIGH_EN  = 14'h0040;
	localparam logic [13:0] ZPOS_LOW_EN   = 14'h0080;
	localparam logic [13:0] DIAG_MAGH     = 14'h0800;
	localparam logic [13:0] DIAG_MAGL     = 14'h0400;
	localparam logic [13:0] DIAG_COF      = 14'h0200;
	localparam logic [13:0] DIAG_LF       = 14'h0100;

	localparam logic [APB_ADDR_W-1:0] REG_COMP_ANGLE = '0;

	typedef enum logic [2:0] {
		FN_READ_REG   = 3'd0,
		FN_READ_FLAGS = 3'd1,
		FN_START_PIPE = 3'd2,
		FN_PIPE_READ  = 3'd3,
		FN_STOP_PIPE  = 3'd4,
		FN_RX_FRAME   = 3'd5,
		FN_XFER_FAIL  = 3'd6,
		FN_NONE       = 3'd7
	} func_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_CMD   = 4'd1,
		PH_NOP   = 4'd2,
		PH_PRIME = 4'd3,
		PH_PIPE  = 4'd4,
		PH_ECMD  = 4'd5,
		PH_ENOP  = 4'd6,
		PH_DCMD  = 4'd7,
		PH_DNOP  = 4'd8,
		PH_ZCMD  = 4'd9,
		PH_ZNOP  = 4'd10
	} phase_t;

	typedef enum logic [1:0] {
		KIND_REG   = 2'd0,
		KIND_FLAGS = 2'd1,
		KIND_PRIME = 2'd2,
		KIND_PIPE  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_PARITY = 3'd1,
		ST_INVAL  = 3'd2,
		ST_MISUSE = 3'd3,
		ST_DIAG   = 3'd4,
		ST_BUS    = 3'd5
	} status_t;

	typedef struct packed {
		phase_t      phase;
		kind_t       kind;
		logic        pipe_on;
		logic [2:0]  last_flags;
		logic [13:0] diag_word;
	} seq_state_t;

	typedef struct packed {
		logic        send;
		logic [15:0] tx_frame;
		logic        done_res;
		status_t     status;
		logic [13:0] read_value;
		logic [2:0]  error_flags;
	} seq_result_t;

	function automatic logic [15:0] read_cmd(input logic [13:0] addr);
		read_cmd = {^{1'b1, addr}, 1'b1, addr};
	endfunction

endpackage

/* design/esrs_in_if.sv */
interface esrs_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [13:0] address;
	logic [15:0] rx_frame;

	modport source (output valid, func, address, rx_frame, input ready);
	modport sink (input valid, func, address, rx_frame, output ready);
endinterface

/* design/esrs_out_if.sv */
interface esrs_out_if;
	logic        valid;
	logic        ready;
	logic        send;
	logic [15:0] tx_frame;
	logic        done_res;
	logic [2:0]  status;
	logic [13:0] read_value;
	logic [2:0]  error_flags;

	modport source (output valid, send, tx_frame, done_res, status, read_value, error_flags,
		input ready);
	modport sink (input valid, send, tx_frame, done_res, status, read_value, error_flags,
		output ready);
endinterface

/* design/encoder_spi_read_sequencer.sv */
// channel   dir  payload                                              beat when
// in_ch     in   func, address, rx_frame                              valid & ready
// out_ch    out  send, tx_frame, done_res, status, read_value,        valid & ready
//                error_flags
// apb       in   comp_angle at byte address 0                         psel & penable & pwrite
//
// An input beat reaches the result beat through the input register, then the result register.
// One item per cycle while out_ch is ready; the only loop is the sequencer state register.
// arst_n clears both stage valids, the sequencer state and comp_angle (to 1).
// A stalled output holds its beat; the input stage still takes one beat meanwhile.
module encoder_spi_read_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	esrs_in_if.sink                           in_ch,
	esrs_out_if.source                        out_ch,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [esrs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [esrs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [esrs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	logic                  v_s1;
	logic [2:0]            func_s1;
	logic [13:0]           addr_s1;
	logic [15:0]           rx_s1;
	logic                  v_s2;
	esrs_pkg::seq_result_t res_s2;
	esrs_pkg::seq_state_t  state_q;
	esrs_pkg::seq_state_t  state_nxt;
	esrs_pkg::seq_result_t res_nxt;
	logic                  comp_angle_q;
	logic                  advance;
	logic                  reg_sel;

	assign advance     = !v_s2 || out_ch.ready;
	assign in_ch.ready = !v_s1 || advance;

	// word-aligned decode: byte offset bits ignored
	assign reg_sel = (paddr[esrs_pkg::APB_ADDR_W-1:2]
		== esrs_pkg::REG_COMP_ANGLE[esrs_pkg::APB_ADDR_W-1:2]);
	assign pready  = 1'b1;
	assign prdata  = reg_sel ? {{(esrs_pkg::APB_DATA_W-1){1'b0}}, comp_angle_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_angle_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			comp_angle_q <= pwdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			func_s1 <= in_ch.func;
			addr_s1 <= in_ch.address;
			rx_s1   <= in_ch.rx_frame;
		end
	end

	esrs_step u_step (
		.cur        (state_q),
		.func       (func_s1),
		.address    (addr_s1),
		.rx_frame   (rx_s1),
		.comp_angle (comp_angle_q),
		.nxt        (state_nxt),
		.res        (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			state_q <= '0;
		end else if (advance) begin
			v_s2 <= v_s1;
			if (v_s1)
				state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1)
			res_s2 <= res_nxt;
	end

	assign out_ch.valid       = v_s2;
	assign out_ch.send        = res_s2.send;
	assign out_ch.tx_frame    = res_s2.tx_frame;
	assign out_ch.done_res    = res_s2.done_res;
	assign out_ch.status      = res_s2.status;
	assign out_ch.read_value  = res_s2.read_value;
	assign out_ch.error_flags = res_s2.error_flags;

endmodule

/* design/esrs_step.sv */
module esrs_step (
	input  esrs_pkg::seq_state_t  cur,
	input  logic [2:0]            func,
	input  logic [13:0]           address,
	input  logic [15:0]           rx_frame,
	input  logic                  comp_angle,
	output esrs_pkg::seq_state_t  nxt,
	output esrs_pkg::seq_result_t res
);

	logic [13:0] data;
	logic        err_bit;
	logic        rx_odd;
	logic [13:0] angle_addr;
	logic        fault;
	logic        busy;

	assign data       = rx_frame[13:0];
	assign err_bit    = rx_frame[14];
	assign rx_odd     = ^rx_frame;
	assign angle_addr = comp_angle ? esrs_pkg::ADDR_ANG_COMP : esrs_pkg::ADDR_ANG_UNC;
	assign busy       = (cur.phase != esrs_pkg::PH_IDLE);

	// zero-position word against diagnostics word
	assign fault = (((data & esrs_pkg::ZPOS_HIGH_EN) != '0)
			&& ((cur.diag_word & esrs_pkg::DIAG_MAGL) != '0))
		|| (((data & esrs_pkg::ZPOS_LOW_EN) != '0)
			&& ((cur.diag_word & esrs_pkg::DIAG_MAGH) != '0))
		|| ((cur.diag_word & esrs_pkg::DIAG_COF) != '0)
		|| ((cur.diag_word & esrs_pkg::DIAG_LF) == '0);

	always_comb begin
		nxt = cur;
		res = '0;

		if (func <= esrs_pkg::FN_STOP_PIPE && busy) begin
			res.done_res = 1'b1;
			res.status   = esrs_pkg::ST_MISUSE;
		end else begin
			case (esrs_pkg::func_t'(func))
				esrs_pkg::FN_READ_REG, esrs_pkg::FN_READ_FLAGS,
				esrs_pkg::FN_START_PIPE: begin
					if (cur.pipe_on) begin
						res.done_res = 1'b1;
						res.status   = esrs_pkg::ST_MISUSE;
						nxt.phase    = esrs_pkg::PH_IDLE;
					end else if (func == esrs_pkg::FN_READ_REG) begin
						nxt.kind     = esrs_pkg::KIND_REG;
						res.send     = 1'b1;
						res.tx_frame = esrs_pkg::read_cmd(address);
						nxt.phase    = esrs_pkg::PH_CMD;
					end else if (func == esrs_pkg::FN_READ_FLAGS) begin
						nxt.kind     = esrs_pkg::KIND_FLAGS;
						res.send     = 1'b1;
						res.tx_frame = esrs_pkg::read_cmd(esrs_pkg::ADDR_ERRFL);
						nxt.phase    = esrs_pkg::PH_CMD;
					end else begin
						nxt.kind     = esrs_pkg::KIND_PRIME;
						res.send     = 1'b1;
						res.tx_frame = esrs_pkg::read_cmd(angle_addr);
						nxt.phase    = esrs_pkg::PH_PRIME;
					end
				end
				esrs_pkg::FN_PIPE_READ: begin
					if (!cur.pipe_on) begin
						res.done_res = 1'b1;
						res.status   = esrs_pkg::ST_MISUSE;
						nxt.phase    = esrs_pkg::PH_IDLE;
					end else begin
						nxt.kind     = esrs_pkg::KIND_PIPE;
						res.send     = 1'b1;
						res.tx_frame = esrs_pkg::read_cmd(angle_addr);
						nxt.phase    = esrs_pkg::PH_PIPE;
					end
				end
				esrs_pkg::FN_STOP_PIPE: begin
					res.done_res = 1'b1;
					nxt.phase    = esrs_pkg::PH_IDLE;
					if (!cur.pipe_on) begin
						res.status = esrs_pkg::ST_MISUSE;
					end else begin
						nxt.pipe_on = 1'b0;
						res.status  = esrs_pkg::ST_OK;
					end
				end
				esrs_pkg::FN_XFER_FAIL: begin
					if (busy) begin
						if (cur.phase == esrs_pkg::PH_PIPE)
							nxt.pipe_on = 1'b0;
						res.done_res = 1'b1;
						res.status   = esrs_pkg::ST_BUS;
						nxt.phase    = esrs_pkg::PH_IDLE;
					end
				end
				esrs_pkg::FN_RX_FRAME: begin
					if (busy && rx_odd) begin
						if (cur.phase == esrs_pkg::PH_PIPE)
							nxt.pipe_on = 1'b0;
						res.done_res = 1'b1;
						res.status   = esrs_pkg::ST_PARITY;
						nxt.phase    = esrs_pkg::PH_IDLE;
					end else if (busy) begin
						case (cur.phase)
							esrs_pkg::PH_CMD, esrs_pkg::PH_ECMD, esrs_pkg::PH_DCMD,
							esrs_pkg::PH_ZCMD: begin
								res.send     = 1'b1;
								res.tx_frame = esrs_pkg::read_cmd(esrs_pkg::ADDR_NOP);
								case (cur.phase)
									esrs_pkg::PH_CMD:  nxt.phase = esrs_pkg::PH_NOP;
									esrs_pkg::PH_ECMD: nxt.phase = esrs_pkg::PH_ENOP;
									esrs_pkg::PH_DCMD: nxt.phase = esrs_pkg::PH_DNOP;
									default:           nxt.phase = esrs_pkg::PH_ZNOP;
								endcase
							end
							esrs_pkg::PH_NOP: begin
								if (cur.kind == esrs_pkg::KIND_FLAGS) begin
									nxt.last_flags = data[2:0];
									res.done_res   = 1'b1;
									res.status     = esrs_pkg::ST_OK;
									res.read_value = data;
									nxt.phase      = esrs_pkg::PH_IDLE;
								end else if (err_bit) begin
									res.send     = 1'b1;
									res.tx_frame = esrs_pkg::read_cmd(esrs_pkg::ADDR_ERRFL);
									nxt.phase    = esrs_pkg::PH_ECMD;
								end else begin
									res.done_res   = 1'b1;
									res.status     = esrs_pkg::ST_OK;
									res.read_value = data;
									nxt.phase      = esrs_pkg::PH_IDLE;
								end
							end
							esrs_pkg::PH_PRIME: begin
								nxt.pipe_on  = 1'b1;
								res.done_res = 1'b1;
								res.status   = esrs_pkg::ST_OK;
								nxt.phase    = esrs_pkg::PH_IDLE;
							end
							esrs_pkg::PH_PIPE: begin
								if (err_bit) begin
									nxt.pipe_on  = 1'b0;
									res.send     = 1'b1;
									res.tx_frame = esrs_pkg::read_cmd(esrs_pkg::ADDR_ERRFL);
									nxt.phase    = esrs_pkg::PH_ECMD;
								end else begin
									res.done_res   = 1'b1;
									res.status     = esrs_pkg::ST_OK;
									res.read_value = data;
									nxt.phase      = esrs_pkg::PH_IDLE;
								end
							end
							esrs_pkg::PH_ENOP: begin
								nxt.last_flags = data[2:0];
								if (data[2]) begin
									res.done_res = 1'b1;
									res.status   = esrs_pkg::ST_PARITY;
									nxt.phase    = esrs_pkg::PH_IDLE;
								end else if (data[1:0] != 2'b00) begin
									res.done_res = 1'b1;
									res.status   = esrs_pkg::ST_INVAL;
									nxt.phase    = esrs_pkg::PH_IDLE;
								end else begin
									res.send     = 1'b1;
									res.tx_frame = esrs_pkg::read_cmd(esrs_pkg::ADDR_DIAAGC);
									nxt.phase    = esrs_pkg::PH_DCMD;
								end
							end
							esrs_pkg::PH_DNOP: begin
								nxt.diag_word = data;
								res.send      = 1'b1;
								res.tx_frame  = esrs_pkg::read_cmd(esrs_pkg::ADDR_ZPOSL);
								nxt.phase     = esrs_pkg::PH_ZCMD;
							end
							esrs_pkg::PH_ZNOP: begin
								res.done_res = 1'b1;
								res.status   = fault ? esrs_pkg::ST_DIAG : esrs_pkg::ST_INVAL;
								nxt.phase    = esrs_pkg::PH_IDLE;
							end
							default: begin
							end
						endcase
					end
				end
				default: begin
				end
			endcase
		end

		res.error_flags = nxt.last_flags;
	end

endmodule

/* sim/esrs_checker.sv */
`timescale 1ns / 1ps

module esrs_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	esrs_in_if                              in_ch,
	esrs_out_if                             out_ch,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [esrs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [31:0]                     pwdata,
	input  logic [31:0]                     prdata,
	input  logic                            pready,
	output int                              errors,
	output int                              pending,
	output int                              beats_in,
	output int                              beats_out,
	output int                              frames_sent,
	output logic [5:0][15:0]                tally
);
	import esrs_pkg::*;

	phase_t      phase;
	kind_t       kind;
	logic        pipe_on;
	logic [2:0]  flags;
	logic [13:0] diag;
	logic        angle_src;

	seq_result_t res;
	seq_result_t awaited_results[$];

	int              fails;
	int              n_in;
	int              n_out;
	int              n_send;
	logic [5:0][15:0] n_status;

	function automatic logic [15:0] cmd_frame(input logic [13:0] a);
		logic [15:0] f;
		f = {2'b01, a};
		f[15] = ^f[14:0];
		return f;
	endfunction

	function automatic void send_command(input logic [13:0] a, input phase_t nxt);
		res.send = 1'b1;
		res.tx_frame = cmd_frame(a);
		phase = nxt;
	endfunction

	function automatic void end_request(input status_t st, input logic [13:0] v);
		res.done_res = 1'b1;
		res.status = st;
		res.read_value = v;
		phase = PH_IDLE;
	endfunction

	function automatic seq_result_t sequencer_step(input func_t fn, input logic [13:0] a,
		input logic [15:0] rx);
		logic [13:0] data;
		logic        errb;
		logic        fault;
		data = rx[13:0];
		errb = rx[14];
		res = '0;
		if (fn <= FN_STOP_PIPE && phase != PH_IDLE) begin
			res.done_res = 1'b1;
			res.status = ST_MISUSE;
		end else begin
			case (fn)
				FN_READ_REG, FN_READ_FLAGS, FN_START_PIPE: begin
					if (pipe_on) begin
						end_request(ST_MISUSE, '0);
					end else if (fn == FN_READ_REG) begin
						kind = KIND_REG;
						send_command(a, PH_CMD);
					end else if (fn == FN_READ_FLAGS) begin
						kind = KIND_FLAGS;
						send_command(ADDR_ERRFL, PH_CMD);
					end else begin
						kind = KIND_PRIME;
						send_command(angle_src ? ADDR_ANG_COMP : ADDR_ANG_UNC, PH_PRIME);
					end
				end
				FN_PIPE_READ: begin
					if (!pipe_on) begin
						end_request(ST_MISUSE, '0);
					end else begin
						kind = KIND_PIPE;
						send_command(angle_src ? ADDR_ANG_COMP : ADDR_ANG_UNC, PH_PIPE);
					end
				end
				FN_STOP_PIPE: begin
					if (!pipe_on) begin
						end_request(ST_MISUSE, '0);
					end else begin
						pipe_on = 1'b0;
						end_request(ST_OK, '0);
					end
				end
				FN_RX_FRAME: begin
					if (phase == PH_IDLE) begin
					end else if (^rx) begin
						if (phase == PH_PIPE)
							pipe_on = 1'b0;
						end_request(ST_PARITY, '0);
					end else begin
						case (phase)
							PH_CMD: send_command(ADDR_NOP, PH_NOP);
							PH_NOP: begin
								if (kind == KIND_FLAGS) begin
									flags = data[2:0];
									end_request(ST_OK, data);
								end else if (errb) begin
									send_command(ADDR_ERRFL, PH_ECMD);
								end else begin
									end_request(ST_OK, data);
								end
							end
							PH_PRIME: begin
								pipe_on = 1'b1;
								end_request(ST_OK, '0);
							end
							PH_PIPE: begin
								if (errb) begin
									pipe_on = 1'b0;
									send_command(ADDR_ERRFL, PH_ECMD);
								end else begin
									end_request(ST_OK, data);
								end
							end
							PH_ECMD: send_command(ADDR_NOP, PH_ENOP);
							PH_ENOP: begin
								flags = data[2:0];
								if (flags[2])
									end_request(ST_PARITY, '0);
								else if (flags[1:0] != 2'b00)
									end_request(ST_INVAL, '0);
								else
									send_command(ADDR_DIAAGC, PH_DCMD);
							end
							PH_DCMD: send_command(ADDR_NOP, PH_DNOP);
							PH_DNOP: begin
								diag = data;
								send_command(ADDR_ZPOSL, PH_ZCMD);
							end
							PH_ZCMD: send_command(ADDR_NOP, PH_ZNOP);
							PH_ZNOP: begin
								fault = ((data & ZPOS_HIGH_EN) != 0 && (diag & DIAG_MAGL) != 0)
									|| ((data & ZPOS_LOW_EN) != 0 && (diag & DIAG_MAGH) != 0)
									|| (diag & DIAG_COF) != 0 || (diag & DIAG_LF) == 0;
								end_request(fault ? ST_DIAG : ST_INVAL, '0);
							end
							default: ;
						endcase
					end
				end
				FN_XFER_FAIL: begin
					if (phase != PH_IDLE) begin
						if (phase == PH_PIPE)
							pipe_on = 1'b0;
						end_request(ST_BUS, '0);
					end
				end
				default: ;
			endcase
		end
		res.error_flags = flags;
		return res;
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		if (fails < 30)
			$display("esrs_checker: mismatch on %s at result %0d: got %h, expected %h",
				what, n_out, got, want);
		fails++;
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		seq_result_t want;
		if (!arst_n) begin
			phase = PH_IDLE;
			kind = KIND_REG;
			pipe_on = 1'b0;
			flags = '0;
			diag = '0;
			angle_src = 1'b1;
			awaited_results.delete();
			fails = 0;
			n_in = 0;
			n_out = 0;
			n_send = 0;
			n_status = '0;
		end else begin
			if (psel && penable && pready && paddr == REG_COMP_ANGLE) begin
				if (pwrite)
					angle_src = pwdata[0];
				else
					compare_field("comp_angle readback", prdata, {31'b0, angle_src});
			end
			if (out_ch.valid && out_ch.ready) begin
				if (awaited_results.size() == 0) begin
					report("result beat with nothing pending", out_ch.tx_frame, '0);
				end else begin
					want = awaited_results.pop_front();
					compare_field("send", out_ch.send, want.send);
					compare_field("tx_frame", out_ch.tx_frame, want.tx_frame);
					compare_field("done_res", out_ch.done_res, want.done_res);
					compare_field("status", out_ch.status, want.status);
					compare_field("read_value", out_ch.read_value, want.read_value);
					compare_field("error_flags", out_ch.error_flags, want.error_flags);
				end
				n_out++;
				if (out_ch.send === 1'b1)
					n_send++;
				if (out_ch.done_res === 1'b1 && out_ch.status <= 3'd5)
					n_status[out_ch.status] = n_status[out_ch.status] + 1'b1;
			end
			if (in_ch.valid && in_ch.ready) begin
				awaited_results.push_back(sequencer_step(func_t'(in_ch.func), in_ch.address,
					in_ch.rx_frame));
				n_in++;
			end
		end
		errors <= fails;
		pending <= awaited_results.size();
		beats_in <= n_in;
		beats_out <= n_out;
		frames_sent <= n_send;
		tally <= n_status;
	end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import esrs_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;

	int               errors;
	int               pending;
	int               beats_in;
	int               beats_out;
	int               frames_sent;
	logic [5:0][15:0] tally;

	int  cycles = 0;
	int  items_sent = 0;
	bit  noisy = 1'b0;
	bit  in_calm = 1'b0;
	int  in_calm_left = 30;

	esrs_in_if  in_ch ();
	esrs_out_if out_ch ();

	encoder_spi_read_sequencer dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	esrs_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.errors      (errors),
		.pending     (pending),
		.beats_in    (beats_in),
		.beats_out   (beats_out),
		.frames_sent (frames_sent),
		.tally       (tally)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("testbench: timeout after %0d cycles, %0d results pending", cycles, pending);
			$display("testbench: FAIL");
			$finish;
		end
	end

	function automatic logic [15:0] miso_frame(input logic errb, input logic [13:0] d,
		input logic corrupt);
		logic [15:0] f;
		f = {1'b0, errb, d};
		f[15] = ^f[14:0] ^ corrupt;
		return f;
	endfunction

	function automatic logic [13:0] pick_addr();
		case ($urandom_range(0, 7))
			0: return 14'h0000;
			1: return 14'h3FFF;
			default: return 14'($urandom);
		endcase
	endfunction

	task automatic put_item(input func_t fn, input logic [13:0] a, input logic [15:0] rx,
		input bit counted);
		int gap;
		gap = in_calm ? 0 : $urandom_range(0, 6);
		if (in_calm_left == 0) begin
			in_calm = !in_calm;
			in_calm_left = $urandom_range(20, 60);
		end else begin
			in_calm_left--;
		end
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func <= fn;
		in_ch.address <= a;
		in_ch.rx_frame <= rx;
		do @(posedge clk); while (!in_ch.ready);
		if (counted)
			items_sent++;
	endtask

	// one reply from the encoder; alive drops when the transfer is spoiled
	task automatic answer(input logic errb, input logic [13:0] d, output bit alive);
		int pick;
		alive = 1'b1;
		if (noisy && $urandom_range(0, 99) < 5)
			put_item(func_t'(3'($urandom_range(0, 4))), pick_addr(), 16'($urandom), 1'b1);
		pick = noisy ? $urandom_range(0, 99) : 99;
		if (pick < 3) begin
			put_item(FN_RX_FRAME, pick_addr(), miso_frame(errb, d, 1'b1), 1'b1);
			alive = 1'b0;
		end else if (pick < 6) begin
			put_item(FN_XFER_FAIL, pick_addr(), 16'($urandom), 1'b1);
			alive = 1'b0;
		end else begin
			put_item(FN_RX_FRAME, pick_addr(), miso_frame(errb, d, 1'b0), 1'b1);
		end
	endtask

	task automatic recover();
		bit          alive;
		logic [2:0]  fl;
		logic [13:0] dw;
		answer(1'($urandom), 14'($urandom), alive);
		if (!alive)
			return;
		fl = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(1, 7));
		answer(1'($urandom), {11'($urandom), fl}, alive);
		if (!alive || fl != 3'd0)
			return;
		answer(1'($urandom), 14'($urandom), alive);
		if (!alive)
			return;
		dw = 14'($urandom);
		if ($urandom_range(0, 1)) begin
			dw = dw | DIAG_LF;
			dw = dw & ~DIAG_COF;
		end
		answer(1'($urandom), dw, alive);
		if (!alive)
			return;
		answer(1'($urandom), 14'($urandom), alive);
		if (!alive)
			return;
		answer(1'($urandom), 14'($urandom), alive);
	endtask

	task automatic reg_read();
		bit   alive;
		logic errb;
		put_item(FN_READ_REG, pick_addr(), 16'($urandom), 1'b1);
		answer(1'($urandom), 14'($urandom), alive);
		if (!alive)
			return;
		errb = ($urandom_range(0, 3) == 0);
		answer(errb, pick_addr(), alive);
		if (alive && errb)
			recover();
	endtask

	task automatic flags_read();
		bit alive;
		put_item(FN_READ_FLAGS, pick_addr(), 16'($urandom), 1'b1);
		answer(1'($urandom), 14'($urandom), alive);
		if (alive)
			answer(1'($urandom), 14'($urandom), alive);
	endtask

	task automatic idle_noise(input bit piped);
		case ($urandom_range(0, 4))
			0: put_item(FN_RX_FRAME, pick_addr(), 16'($urandom), 1'b0);
			1: put_item(FN_XFER_FAIL, pick_addr(), 16'($urandom), 1'b0);
			2: put_item(FN_NONE, pick_addr(), 16'($urandom), 1'b0);
			default: begin
				if (piped)
					put_item(func_t'(3'($urandom_range(0, 2))), pick_addr(), 16'($urandom), 1'b1);
				else
					put_item($urandom_range(0, 1) ? FN_PIPE_READ : FN_STOP_PIPE, pick_addr(),
						16'($urandom), 1'b1);
			end
		endcase
	endtask

	task automatic pipe_session();
		bit   alive;
		logic errb;
		int   reads;
		put_item(FN_START_PIPE, pick_addr(), 16'($urandom), 1'b1);
		answer(1'($urandom), 14'($urandom), alive);
		if (!alive)
			return;
		reads = $urandom_range(1, 8);
		for (int i = 0; i < reads; i++) begin
			if ($urandom_range(0, 9) == 0)
				idle_noise(1'b1);
			put_item(FN_PIPE_READ, pick_addr(), 16'($urandom), 1'b1);
			errb = ($urandom_range(0, 7) == 0);
			answer(errb, pick_addr(), alive);
			if (!alive)
				return;
			if (errb) begin
				recover();
				return;
			end
		end
		put_item(FN_STOP_PIPE, pick_addr(), 16'($urandom), 1'b1);
	endtask

	task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] a,
		input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic set_comp_angle(input logic v);
		drain();
		repeat (4) @(posedge clk);
		apb_access(1'b1, REG_COMP_ANGLE, {31'b0, v});
		apb_access(1'b0, REG_COMP_ANGLE, '0);
	endtask

	task automatic random_traffic(input int count);
		int goal;
		int pick;
		goal = items_sent + count;
		while (items_sent < goal) begin
			pick = $urandom_range(0, 99);
			if (pick < 30)
				reg_read();
			else if (pick < 45)
				flags_read();
			else if (pick < 80)
				pipe_session();
			else
				idle_noise(1'b0);
		end
	endtask

	initial begin : result_sink
		int w;
		int calm_left;
		bit calm;
		calm = 1'b0;
		calm_left = 40;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 6);
			if (w != 0) begin
				out_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
			if (calm_left == 0) begin
				calm = !calm;
				calm_left = $urandom_range(20, 60);
			end else begin
				calm_left--;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.func <= FN_NONE;
		in_ch.address <= '0;
		in_ch.rx_frame <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle-time noise and misuse
		put_item(FN_RX_FRAME, 14'h0000, 16'hFFFF, 1'b0);
		put_item(FN_XFER_FAIL, 14'h3FFF, 16'h0000, 1'b0);
		put_item(FN_NONE, 14'h3FFF, 16'hFFFF, 1'b0);
		put_item(FN_PIPE_READ, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_STOP_PIPE, 14'h0000, 16'h0000, 1'b1);
		// register read, top address, all-ones data
		put_item(FN_READ_REG, 14'h3FFF, 16'h0000, 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b1, 14'h0000, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h3FFF, 1'b0), 1'b1);
		// request while busy, then bad parity
		put_item(FN_READ_FLAGS, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_READ_REG, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h1234, 1'b1), 1'b1);
		// bus failure
		put_item(FN_READ_REG, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_XFER_FAIL, 14'h0000, 16'h0000, 1'b1);
		// error bit, full recovery ending in a diagnostic fault
		put_item(FN_READ_REG, 14'h2AAA, 16'h0000, 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h1555, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b1, 14'h0ABC, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b1, 14'h3FFF, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h3FF8, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b1, 14'h0000, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h0000, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h0000, 1'b0), 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h00C0, 1'b0), 1'b1);
		// pipeline start, misuse while pipelined, one angle, stop
		put_item(FN_START_PIPE, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b1, 14'h2222, 1'b0), 1'b1);
		put_item(FN_READ_REG, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_PIPE_READ, 14'h0000, 16'h0000, 1'b1);
		put_item(FN_RX_FRAME, 14'h0000, miso_frame(1'b0, 14'h3FFF, 1'b0), 1'b1);
		put_item(FN_STOP_PIPE, 14'h0000, 16'h0000, 1'b1);

		noisy = 1'b1;
		set_comp_angle(1'b0);
		random_traffic(190);
		set_comp_angle(1'b1);
		random_traffic(200);
		set_comp_angle(1'b0);
		random_traffic(200);

		drain();
		repeat (10) @(posedge clk);
		$display("testbench: %0d request beats, %0d result beats, %0d command frames,",
			beats_in, beats_out, frames_sent);
		$display("testbench: both angle registers; finished ok %0d parity %0d invalid %0d",
			tally[0], tally[1], tally[2]);
		$display("testbench: misuse %0d fault %0d bus %0d", tally[3], tally[4], tally[5]);
		if (errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
